// ===== hdl/stmc_pkg.sv =====
package stmc_pkg;

    localparam int AngleW = 8;
    localparam int PulseW = 12;
    localparam logic [11:0] LowMin = 12'd100;
    localparam logic [11:0] LowMax = 12'd2000;
    localparam logic [11:0] HighMin = 12'd1800;
    localparam logic [11:0] HighMax = 12'd2600;
    localparam logic [7:0] AngleMax = 8'd180;
    localparam logic [7:0] AngleMid = 8'd90;
    localparam logic [3:0] SecsMax = 4'd9;
    localparam logic [3:0] SecsReset = 4'd3;
    localparam int DivW = 32;
    // ceil(2^27 / 180), exact floor(x / 180) for x < 2^19
    localparam logic [38:0] Recip180 = 39'd745655;

    localparam logic [2:0] ModeMenu = 3'd0;
    localparam logic [2:0] ModeManual = 3'd1;
    localparam logic [2:0] ModeSweep = 3'd2;
    localparam logic [2:0] ModeCenter = 3'd3;
    localparam logic [2:0] ModeSettings = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_DIV,
        ST_PULSE,
        ST_DONE
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // take input, do edits/button
        logic mod_start; // start phase = now mod 2P
        logic div_start; // start angle division
        logic pul_start; // start pulse scaling
        logic finish;    // commit drive angle/pulse
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sweep;     // drive angle comes from the triangle
        logic div_done;
    } dp_status_t;

endpackage

// ===== hdl/stmc_controller.sv =====
module stmc_controller
    import stmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        pend_reg, pend_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid && !in_stall) state_next = ST_MOD;
            ST_MOD:
            begin
                if (!status.sweep)
                    state_next = ST_PULSE;
                else if (status.div_done)
                    state_next = ST_DIV;
            end
            ST_DIV:   if (status.div_done) state_next = ST_PULSE;
            ST_PULSE: if (status.div_done) state_next = ST_DONE;
            ST_DONE:  if (!pend_reg || !out_stall) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (out_valid && !out_stall)
            pend_next = 1'b0;
        if (cmd.finish)
            pend_next = 1'b1;
    end

    always_comb
    begin
        cmd = '0;
        in_stall = !(state_reg == ST_IDLE);
        cmd.load = (state_reg == ST_IDLE) && in_valid && !in_stall;
        cmd.mod_start = cmd.load;
        cmd.div_start = (state_reg == ST_MOD) && status.sweep && status.div_done;
        cmd.pul_start = ((state_reg == ST_MOD) && !status.sweep) ||
                        ((state_reg == ST_DIV) && status.div_done);
        cmd.finish = (state_reg == ST_DONE) && (!pend_reg || !out_stall);
        out_valid = pend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg <= pend_next;
        end
    end

endmodule

// ===== hdl/stmc_datapath.sv =====
module stmc_datapath
    import stmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    input  logic signed [7:0] encoder_delta,
    input  logic              button_pressed,
    input  logic [31:0]       now_ms,
    output logic              drive_valid,
    output logic [11:0]       pulse_us,
    output logic [2:0]        mode_now,
    output logic [1:0]        menu_cursor,
    output logic [2:0]        settings_cursor,
    output logic [7:0]        shown_angle,
    output logic              save_request,
    output logic [10:0]       low_pulse_now,
    output logic [11:0]       high_pulse_now,
    output logic [7:0]        center_now,
    output logic [3:0]        sweep_seconds_now
);

    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  menu_reg, menu_next;
    logic [2:0]  field_reg, field_next;
    logic [7:0]  angle_reg, angle_next;
    logic [11:0] low_reg, low_next;
    logic [11:0] high_reg, high_next;
    logic [7:0]  center_reg, center_next;
    logic [3:0]  secs_reg, secs_next;
    logic        save_reg, save_next;
    logic [7:0]  drive_reg;
    logic [31:0] now_reg;
    logic [14:0] period;

    // shared restoring divider: quotient/remainder of num / den
    logic [DivW-1:0] quo_reg, rem_reg;
    logic [DivW-1:0] den_reg;
    logic [5:0]      cnt_reg;
    logic            busy_reg;
    logic [1:0]      job_reg;
    logic [DivW:0]   trial;
    logic [DivW-1:0] rem_sh;
    logic [38:0]     recip_prod;

    logic signed [13:0] sd;
    logic signed [13:0] acc;
    logic [11:0] span;

    // outputs, held for the transaction
    logic        o_valid_reg;
    logic [11:0] o_pulse_reg;
    logic [2:0]  o_mode_reg;
    logic [1:0]  o_menu_reg;
    logic [2:0]  o_field_reg;
    logic [7:0]  o_angle_reg;
    logic        o_save_reg;
    logic [10:0] o_low_reg;
    logic [11:0] o_high_reg;
    logic [7:0]  o_center_reg;
    logic [3:0]  o_secs_reg;

    function automatic logic signed [13:0] clampv(logic signed [13:0] v,
        logic signed [13:0] lo, logic signed [13:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    assign sd = 14'(encoder_delta);
    assign period = 15'(secs_reg == 4'd0 ? 4'd1 : secs_reg) * 15'd1000;
    assign span = high_reg - low_reg;

    always_comb
    begin
        mode_next = mode_reg;
        menu_next = menu_reg;
        field_next = field_reg;
        angle_next = angle_reg;
        low_next = low_reg;
        high_next = high_reg;
        center_next = center_reg;
        secs_next = secs_reg;
        save_next = 1'b0;
        acc = '0;
        if (encoder_delta != 8'sd0)
        begin
            case (mode_reg)
                ModeMenu:
                    menu_next = 2'(clampv(14'(menu_reg) + sd, 14'sd0, 14'sd3));
                ModeManual:
                    angle_next = 8'(clampv(14'(angle_reg) + sd, 14'sd0, 14'sd180));
                ModeSettings:
                begin
                    case (field_reg)
                        3'd0:
                        begin
                            acc = clampv($signed({2'b0, low_reg}) + sd * 14'sd10,
                                         14'sd100, 14'sd2000);
                            low_next = 12'(acc);
                        end
                        3'd1:
                        begin
                            acc = clampv($signed({2'b0, high_reg}) + sd * 14'sd10,
                                         14'sd1800, 14'sd2600);
                            high_next = 12'(acc);
                        end
                        3'd2:
                            center_next = 8'(clampv(14'(center_reg) + sd,
                                                    14'sd0, 14'sd180));
                        3'd3:
                            secs_next = 4'(clampv(14'(secs_reg) + sd, 14'sd1, 14'sd9));
                        default: ;
                    endcase
                    if (low_next >= high_next)
                        low_next = high_next - 12'd1;
                end
                ModeSweep:
                begin
                    secs_next = 4'(clampv(14'(secs_reg) + sd, 14'sd1, 14'sd9));
                    save_next = 1'b1;
                end
                default: ;
            endcase
        end
        if (button_pressed)
        begin
            case (mode_reg)
                ModeMenu:
                    case (menu_next)
                        2'd0:
                        begin
                            mode_next = ModeManual;
                            angle_next = AngleMid;
                        end
                        2'd1: mode_next = ModeSweep;
                        2'd2: mode_next = ModeCenter;
                        default:
                        begin
                            mode_next = ModeSettings;
                            field_next = 3'd0;
                        end
                    endcase
                ModeManual, ModeSweep, ModeCenter: mode_next = ModeMenu;
                ModeSettings:
                begin
                    field_next = field_reg + 3'd1;
                    if (field_reg >= 3'd3)
                    begin
                        save_next = 1'b1;
                        mode_next = ModeMenu;
                    end
                end
                default: ;
            endcase
        end
    end

    assign status.sweep = (mode_reg == ModeSweep);
    assign status.div_done = busy_reg && (cnt_reg == 6'd0);

    assign rem_sh = {rem_reg[DivW-2:0], quo_reg[DivW-1]};
    assign trial = {1'b0, rem_sh} - {1'b0, den_reg};
    assign recip_prod = 39'(quo_reg[18:0]) * Recip180;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ModeMenu;
            menu_reg <= 2'd0;
            field_reg <= 3'd0;
            angle_reg <= AngleMid;
            low_reg <= LowMin;
            high_reg <= LowMax;
            center_reg <= AngleMid;
            secs_reg <= SecsReset;
            save_reg <= 1'b0;
            busy_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                mode_reg <= mode_next;
                menu_reg <= menu_next;
                field_reg <= field_next;
                angle_reg <= angle_next;
                low_reg <= low_next;
                high_reg <= high_next;
                center_reg <= center_next;
                secs_reg <= secs_next;
                save_reg <= save_next;
            end
            if (cmd.finish)
            begin
                o_valid_reg <= (mode_reg != ModeMenu);
                if (mode_reg == ModeSweep || mode_reg == ModeCenter)
                    angle_reg <= drive_reg;
            end
            if (cmd.mod_start || cmd.div_start || cmd.pul_start)
                busy_reg <= 1'b1;
            else if (status.div_done)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            now_reg <= now_ms;
        if (cmd.mod_start)
        begin
            // first step loads the registered time and the new sweep period
            job_reg <= 2'd0;
            cnt_reg <= 6'd33;
            quo_reg <= '0;
            rem_reg <= '0;
            den_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            // rem_reg holds phase
            job_reg <= 2'd1;
            cnt_reg <= 6'(DivW);
            den_reg <= 32'(period);
            rem_reg <= '0;
            if (rem_reg < 32'(period))
                quo_reg <= rem_reg * 32'd180;
            else
                quo_reg <= (rem_reg - 32'(period)) * 32'd180;
            drive_reg <= (rem_reg < 32'(period)) ? 8'd0 : 8'd1;
        end
        else if (cmd.pul_start)
        begin
            // angle * span, scaled by 1/180 in the next cycle
            job_reg <= 2'd2;
            cnt_reg <= 6'd1;
            den_reg <= 32'd180;
            rem_reg <= '0;
            if (job_reg == 2'd1)
            begin
                logic [7:0] a;
                a = drive_reg[0] ? 8'(AngleMax - quo_reg[7:0]) : quo_reg[7:0];
                drive_reg <= a;
                quo_reg <= 32'(a) * 32'(span);
            end
            else
            begin
                logic [7:0] a;
                case (mode_reg)
                    ModeCenter: a = center_reg;
                    ModeSettings:
                        case (field_reg)
                            3'd0:    a = 8'd0;
                            3'd1:    a = AngleMax;
                            3'd2:    a = center_reg;
                            default: a = angle_reg;
                        endcase
                    default: a = angle_reg;
                endcase
                drive_reg <= a;
                quo_reg <= 32'(a) * 32'(span);
            end
        end
        else if (busy_reg && cnt_reg != 6'd0)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (job_reg == 2'd0 && cnt_reg == 6'd33)
            begin
                quo_reg <= now_reg;
                den_reg <= {16'd0, period, 1'b0};
            end
            else if (job_reg == 2'd2)
            begin
                quo_reg <= 32'(recip_prod[38:27]);
            end
            else
            begin
                if (!trial[DivW])
                begin
                    rem_reg <= trial[DivW-1:0];
                    quo_reg <= {quo_reg[DivW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[DivW-2:0], 1'b0};
                end
            end
        end
        if (cmd.finish)
        begin
            o_pulse_reg <= (mode_reg != ModeMenu) ? 12'(low_reg + quo_reg[11:0]) : 12'd0;
            o_mode_reg <= mode_reg;
            o_menu_reg <= menu_reg;
            o_field_reg <= field_reg;
            o_angle_reg <= (mode_reg == ModeSweep || mode_reg == ModeCenter) ?
                           drive_reg : angle_reg;
            o_save_reg <= save_reg;
            o_low_reg <= low_reg[10:0];
            o_high_reg <= high_reg;
            o_center_reg <= center_reg;
            o_secs_reg <= secs_reg;
        end
    end

    assign drive_valid = o_valid_reg;
    assign pulse_us = o_pulse_reg;
    assign mode_now = o_mode_reg;
    assign menu_cursor = o_menu_reg;
    assign settings_cursor = o_field_reg;
    assign shown_angle = o_angle_reg;
    assign save_request = o_save_reg;
    assign low_pulse_now = o_low_reg;
    assign high_pulse_now = o_high_reg;
    assign center_now = o_center_reg;
    assign sweep_seconds_now = o_secs_reg;

endmodule

// ===== hdl/servo_tester_mode_controller_unit.sv =====
// Servo tester mode controller. One transaction per control-loop pass: the
// pass is accepted when in_valid is high and in_stall low, and its result is
// presented on out_valid until taken. In sweep mode the result waits on the
// bit-serial divider that forms the sweep phase and the sweep angle one bit
// a cycle; the pulse width is scaled by a reciprocal multiply. The input is
// ready again in the same cycle as the result appears. Results sit in an
// output register, so the next pass is accepted while a result still
// waits; that pass completes only once the prior result is taken.
module servo_tester_mode_controller_unit
    import stmc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic signed [7:0] encoder_delta,
    input  logic              button_pressed,
    input  logic [31:0]       now_ms,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              drive_valid,
    output logic [11:0]       pulse_us,
    output logic [2:0]        mode_now,
    output logic [1:0]        menu_cursor,
    output logic [2:0]        settings_cursor,
    output logic [7:0]        shown_angle,
    output logic              save_request,
    output logic [10:0]       low_pulse_now,
    output logic [11:0]       high_pulse_now,
    output logic [7:0]        center_now,
    output logic [3:0]        sweep_seconds_now
);

    dp_cmd_t    cmd;
    dp_status_t status;

    stmc_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    stmc_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .encoder_delta     (encoder_delta),
        .button_pressed    (button_pressed),
        .now_ms            (now_ms),
        .drive_valid       (drive_valid),
        .pulse_us          (pulse_us),
        .mode_now          (mode_now),
        .menu_cursor       (menu_cursor),
        .settings_cursor   (settings_cursor),
        .shown_angle       (shown_angle),
        .save_request      (save_request),
        .low_pulse_now     (low_pulse_now),
        .high_pulse_now    (high_pulse_now),
        .center_now        (center_now),
        .sweep_seconds_now (sweep_seconds_now)
    );

endmodule

// ===== hdl/stmc_checker.sv =====
module stmc_checker
    import stmc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        drive_valid,
    input logic [11:0] pulse_us,
    input logic [2:0]  mode_now,
    input logic [10:0] low_pulse_now,
    input logic [11:0] high_pulse_now
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pulse_us))
        else $error("result dropped while stalled");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> low_pulse_now < high_pulse_now)
        else $error("low pulse not below high pulse");

    a_menu: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_valid |-> mode_now != ModeMenu)
        else $error("drive in menu mode");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second pass accepted during work");

endmodule

bind servo_tester_mode_controller_unit stmc_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .drive_valid    (drive_valid),
    .pulse_us       (pulse_us),
    .mode_now       (mode_now),
    .low_pulse_now  (low_pulse_now),
    .high_pulse_now (high_pulse_now)
);

// ===== tb/tb_servo_tester_mode_controller_unit.sv =====
module tb_servo_tester_mode_controller_unit
    import stmc_pkg::*;
;

    typedef struct packed {
        logic signed [7:0] delta;
        logic              press;
        logic [31:0]       now;
    } pass_t;

    typedef struct packed {
        logic        drv;
        logic [11:0] pulse;
        logic [2:0]  mode;
        logic [1:0]  mcur;
        logic [2:0]  scur;
        logic [7:0]  angle;
        logic        save;
        logic [10:0] lowp;
        logic [11:0] highp;
        logic [7:0]  center;
        logic [3:0]  secs;
    } status_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic signed [7:0] encoder_delta;
    logic              button_pressed;
    logic [31:0]       now_ms;
    logic              out_valid;
    logic              out_stall;
    logic              drive_valid;
    logic [11:0]       pulse_us;
    logic [2:0]        mode_now;
    logic [1:0]        menu_cursor;
    logic [2:0]        settings_cursor;
    logic [7:0]        shown_angle;
    logic              save_request;
    logic [10:0]       low_pulse_now;
    logic [11:0]       high_pulse_now;
    logic [7:0]        center_now;
    logic [3:0]        sweep_seconds_now;

    servo_tester_mode_controller_unit i_dut (.*);

    pass_t   pending_passes[$];
    status_t expected_status[$];
    int      errors;
    int      accepted;
    int      received;
    int      sweep_passes;
    int      saves_seen;
    bit      stim_done;
    int      hold_off;

    logic [2:0]  p_mode;
    logic [1:0]  p_menu;
    logic [2:0]  p_field;
    int          p_angle;
    int          p_low;
    int          p_high;
    int          p_center;
    int          p_secs;

    function automatic int clamp(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int sweep_angle(logic [31:0] now);
        longint per;
        longint ph;
        per = (p_secs == 0 ? 1 : p_secs) * 1000;
        ph = longint'(now) % (2 * per);
        if (ph < per) return int'((ph * 180) / per);
        return 180 - int'(((ph - per) * 180) / per);
    endfunction

    function automatic status_t predict_pass(pass_t p);
        status_t r;
        int d;
        int drive;
        int nxt;
        bit save;
        d = p.delta;
        save = 0;
        if (d != 0)
        begin
            case (p_mode)
                ModeMenu: p_menu = 2'(clamp(int'(p_menu) + d, 0, 3));
                ModeManual: p_angle = clamp(p_angle + d, 0, 180);
                ModeSettings:
                begin
                    case (p_field)
                        3'd0: p_low = clamp(p_low + d * 10, 100, 2000);
                        3'd1: p_high = clamp(p_high + d * 10, 1800, 2600);
                        3'd2: p_center = clamp(p_center + d, 0, 180);
                        3'd3: p_secs = clamp(p_secs + d, 1, 9);
                        default: ;
                    endcase
                    if (p_low >= p_high) p_low = p_high - 1;
                end
                ModeSweep:
                begin
                    p_secs = clamp(p_secs + d, 1, 9);
                    save = 1;
                end
                default: ;
            endcase
        end
        if (p.press)
        begin
            case (p_mode)
                ModeMenu:
                begin
                    case (p_menu)
                        2'd0:
                        begin
                            p_mode = ModeManual;
                            p_angle = 90;
                        end
                        2'd1: p_mode = ModeSweep;
                        2'd2: p_mode = ModeCenter;
                        default:
                        begin
                            p_mode = ModeSettings;
                            p_field = 3'd0;
                        end
                    endcase
                end
                ModeManual, ModeSweep, ModeCenter: p_mode = ModeMenu;
                ModeSettings:
                begin
                    nxt = p_field + 1;
                    p_field = nxt[2:0];
                    if (nxt >= 4)
                    begin
                        save = 1;
                        p_mode = ModeMenu;
                    end
                end
                default: ;
            endcase
        end
        drive = p_angle;
        if (p_mode == ModeCenter)
        begin
            drive = p_center;
            p_angle = p_center;
        end
        else if (p_mode == ModeSweep)
        begin
            drive = sweep_angle(p.now);
            p_angle = drive;
        end
        else if (p_mode == ModeSettings)
        begin
            if (p_field == 0) drive = 0;
            else if (p_field == 1) drive = 180;
            else if (p_field == 2) drive = p_center;
        end
        r.drv = p_mode != ModeMenu;
        r.pulse = r.drv ? 12'(p_low + (drive * (p_high - p_low)) / 180) : 12'd0;
        r.mode = p_mode;
        r.mcur = p_menu;
        r.scur = p_field;
        r.angle = 8'(p_angle);
        r.save = save;
        r.lowp = 11'(p_low);
        r.highp = 12'(p_high);
        r.center = 8'(p_center);
        r.secs = 4'(p_secs);
        return r;
    endfunction

    function automatic pass_t mk(int d, bit b, logic [31:0] t);
        pass_t p;
        p.delta = 8'(d);
        p.press = b;
        p.now = t;
        return p;
    endfunction

    function automatic logic [31:0] rnd_time();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 20000);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 20000);
            default: return $urandom;
        endcase
    endfunction

    always #1 clk = ~clk;

    initial
    begin
        pass_t p;
        int d;
        clk = 0;
        rst_n = 0;
        errors = 0;
        stim_done = 0;
        hold_off = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        // menu clamps, settings entry, every settings field, extremes for low, center and seconds
        pending_passes.push_back(mk(-128, 0, 0));
        pending_passes.push_back(mk(127, 0, 0));
        pending_passes.push_back(mk(0, 1, 0));
        pending_passes.push_back(mk(127, 0, 1));
        pending_passes.push_back(mk(-128, 0, 2));
        pending_passes.push_back(mk(0, 1, 3));
        pending_passes.push_back(mk(-3, 1, 0));
        pending_passes.push_back(mk(1, 1, 0));
        pending_passes.push_back(mk(5, 0, 32'hFFFF_FFFF));
        pending_passes.push_back(mk(-128, 0, 2999));
        pending_passes.push_back(mk(0, 1, 3000));
        pending_passes.push_back(mk(1, 1, 0));
        pending_passes.push_back(mk(0, 1, 0));
        pending_passes.push_back(mk(3, 1, 0));
        pending_passes.push_back(mk(127, 0, 0));
        pending_passes.push_back(mk(-128, 1, 0));
        pending_passes.push_back(mk(-128, 0, 0));
        pending_passes.push_back(mk(127, 1, 0));
        pending_passes.push_back(mk(-128, 0, 0));
        pending_passes.push_back(mk(127, 1, 0));
        pending_passes.push_back(mk(127, 1, 0));
        pending_passes.push_back(mk(-2, 1, 0));
        pending_passes.push_back(mk(0, 1, 32'h8000_0000));
        for (int i = 0; i < 850; i++)
        begin
            if ($urandom_range(0, 4) == 0) d = $urandom_range(0, 255) - 128;
            else d = $urandom_range(0, 12) - 6;
            if ($urandom_range(0, 3) == 0) d = 0;
            pending_passes.push_back(mk(d, $urandom_range(0, 3) == 0, rnd_time()));
        end
        stim_done = 1;
    end

    int in_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 0;
            encoder_delta <= 0;
            button_pressed <= 0;
            now_ms <= 0;
            in_gap <= 0;
            accepted <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_status.push_back(predict_pass({encoder_delta, button_pressed,
                                                        now_ms}));
                accepted <= accepted + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0 || pending_passes.size() == 0)
                begin
                    in_valid <= 0;
                    if (in_gap > 0) in_gap <= in_gap - 1;
                end
                else
                begin
                    {encoder_delta, button_pressed, now_ms} <= pending_passes.pop_front();
                    in_valid <= 1;
                    in_gap <= (accepted % 200 < 60) ? 0 : $urandom_range(0, 5);
                end
            end
        end
    end

    int out_gap;
    always @(posedge clk or negedge rst_n)
    begin
        status_t got;
        status_t want;
        if (!rst_n)
        begin
            out_stall <= 1;
            out_gap <= 0;
            received <= 0;
            sweep_passes <= 0;
            saves_seen <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {drive_valid, pulse_us, mode_now, menu_cursor, settings_cursor,
                       shown_angle, save_request, low_pulse_now, high_pulse_now,
                       center_now, sweep_seconds_now};
                received <= received + 1;
                if (expected_status.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (got.mode == ModeSweep) sweep_passes <= sweep_passes + 1;
                    if (got.save) saves_seen <= saves_seen + 1;
                    if (got.drv !== want.drv || got.pulse !== want.pulse ||
                        got.mode !== want.mode || got.mcur !== want.mcur ||
                        got.scur !== want.scur || got.angle !== want.angle ||
                        got.save !== want.save || got.lowp !== want.lowp ||
                        got.highp !== want.highp || got.center !== want.center ||
                        got.secs !== want.secs)
                    begin
                        $display("%0t: mismatch exp drv=%0d pulse=%0d mode=%0d mc=%0d sc=%0d",
                                 $time, want.drv, want.pulse, want.mode, want.mcur,
                                 want.scur);
                        $display("    ang=%0d save=%0d lo=%0d hi=%0d ctr=%0d secs=%0d",
                                 want.angle, want.save, want.lowp, want.highp,
                                 want.center, want.secs);
                        $display("  act drv=%0d pulse=%0d mode=%0d mc=%0d sc=%0d",
                                 got.drv, got.pulse, got.mode, got.mcur, got.scur);
                        $display("    ang=%0d save=%0d lo=%0d hi=%0d ctr=%0d secs=%0d",
                                 got.angle, got.save, got.lowp, got.highp,
                                 got.center, got.secs);
                        errors <= errors + 1;
                    end
                end
            end
            if (accepted == 300 && hold_off == 0)
            begin
                hold_off <= 1;
                out_gap <= 600;
                out_stall <= 1;
            end
            else if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_stall <= 1;
            end
            else if (out_valid && out_stall)
            begin
                out_stall <= 0;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 1) == 0);
                if (received % 200 >= 60) out_gap <= $urandom_range(0, 5);
            end
        end
    end

    initial
    begin
        p_mode = ModeMenu;
        p_menu = 0;
        p_field = 0;
        p_angle = 90;
        p_low = 100;
        p_high = 2000;
        p_center = 90;
        p_secs = 3;
        wait (stim_done && rst_n);
        wait (pending_passes.size() == 0 && !in_valid && expected_status.size() == 0);
        repeat (200) @(posedge clk);
        $display("%0d passes checked, %0d in sweep, %0d with save flagged",
                 received, sweep_passes, saves_seen);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end
endmodule
